@@ src/mpcs_pkg.sv @@
package mpcs_pkg;

  localparam int COLOR_BITS = 12;
  localparam int CHAN_W     = COLOR_BITS;
  localparam int RGB_W      = 3 * CHAN_W;
  localparam int XY_W       = 32;
  localparam int COORD_W    = 16;
  localparam int SLOT_W     = 16;
  localparam int MAX_PIXELS = 1 << SLOT_W;
  localparam int PICK_W     = 12;
  localparam int DIST_W     = 25;
  localparam int SCORE_W    = 18;
  localparam int ALPHA_W    = 13;
  localparam int RATIO_W    = 16;
  localparam int COST_W     = 19;
  localparam int MUL_W      = 27;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int DIV_W      = 26;
  localparam int REM_W      = DIV_W + 1;
  localparam int SQ_W       = 52;
  localparam int SQ_STEPS   = 26;
  localparam int CNT_W      = 5;

  localparam logic [SCORE_W-1:0] SCORE_MAX = '1;
  localparam logic [ALPHA_W-1:0] ALPHA_ONE = 13'd4096;
  localparam logic [RATIO_W-1:0] RATIO_MAX = '1;
  localparam logic [RATIO_W-1:0] RATIO_ONE = 16'd256;
  localparam logic [SQ_W-1:0]    SQ_BIT0   = 52'h4_0000_0000_0000;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_ND,
    S_ALPHA,
    S_ADIV,
    S_RES,
    S_SQRT,
    S_CSCALE,
    S_DSQ,
    S_RATIO,
    S_RDIV,
    S_UPDATE,
    S_OUT
  } state_t;

endpackage

@@ src/matting_pair_cost_selector.sv @@
// Scores one foreground/background candidate pair per transaction and keeps the cheapest pair of
// a run; a transaction with last_of_run set produces one result transaction after the run's best
// pair has been re-blended against that transaction's pixel. After reset the block sweeps its
// 65536-entry distance memory to all ones, one entry per cycle, and takes no input until the
// sweep is done. All arithmetic runs on one 27x27 multiplier, one restoring divider step and one
// square-root step under a sequencer, so the alpha divide, each distance ratio and each of the
// three square roots of a candidate run one after another, and a last_of_run candidate also
// recomputes the emitted alpha. in_stall is low only while the sequencer is idle; a finished
// result waits in the output register without blocking the next candidate, though a new result
// waits in the output state while the register still holds a stalled one.
module matting_pair_cost_selector
  import mpcs_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [SLOT_W-1:0]   in_pixel_slot,
  input  logic [RGB_W-1:0]    in_pixel_rgb,
  input  logic [XY_W-1:0]     in_pixel_xy,
  input  logic [RGB_W-1:0]    in_fg_rgb,
  input  logic [XY_W-1:0]     in_fg_xy,
  input  logic [RGB_W-1:0]    in_bg_rgb,
  input  logic [XY_W-1:0]     in_bg_xy,
  input  logic [PICK_W-1:0]   in_fg_pick,
  input  logic [PICK_W-1:0]   in_bg_pick,
  input  logic                in_first_of_run,
  input  logic                in_last_of_run,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [PICK_W-1:0]   out_best_fg_pick,
  output logic [PICK_W-1:0]   out_best_bg_pick,
  output logic [SCORE_W-1:0]  out_best_score,
  output logic [ALPHA_W-1:0]  out_alpha_value
);

  state_t state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [SLOT_W-1:0] clr_r, clr_nxt;
  logic emit_r, emit_nxt;
  logic side_r, side_nxt;
  logic sq_dist_r, sq_dist_nxt;
  logic out_valid_r, out_valid_nxt;

  logic [SCORE_W-1:0] best_score_r, best_score_nxt;
  logic [PICK_W-1:0]  best_fg_pick_r, best_fg_pick_nxt;
  logic [PICK_W-1:0]  best_bg_pick_r, best_bg_pick_nxt;
  logic [RGB_W-1:0]   best_fg_rgb_r, best_fg_rgb_nxt;
  logic [RGB_W-1:0]   best_bg_rgb_r, best_bg_rgb_nxt;

  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [RGB_W-1:0]  pix_rgb_r, pix_rgb_nxt;
  logic [XY_W-1:0]   pix_xy_r, pix_xy_nxt;
  logic [RGB_W-1:0]  fg_rgb_r, fg_rgb_nxt;
  logic [XY_W-1:0]   fg_xy_r, fg_xy_nxt;
  logic [RGB_W-1:0]  bg_rgb_r, bg_rgb_nxt;
  logic [XY_W-1:0]   bg_xy_r, bg_xy_nxt;
  logic [PICK_W-1:0] fg_pick_r, fg_pick_nxt;
  logic [PICK_W-1:0] bg_pick_r, bg_pick_nxt;
  logic first_r, first_nxt;
  logic last_r, last_nxt;

  logic signed [MUL_W-1:0] num_r, num_nxt;
  logic [MUL_W-1:0]        den_r, den_nxt;
  logic [ALPHA_W-1:0]      alpha_r, alpha_nxt;
  logic [REM_W-1:0]        rem_r, rem_nxt;
  logic [RATIO_W-1:0]      quo_r, quo_nxt;
  logic [RATIO_W-1:0]      dlow_r, dlow_nxt;
  logic [DIV_W-1:0]        div_d_r, div_d_nxt;
  logic signed [MUL_W-1:0] rr_r, rr_nxt;
  logic [SQ_W-1:0]         sum_r, sum_nxt;
  logic [SQ_W-1:0]         sv_r, sv_nxt;
  logic [SQ_W:0]           sres_r, sres_nxt;
  logic [SQ_W-1:0]         sbit_r, sbit_nxt;
  logic [COST_W-1:0]       cost_r, cost_nxt;
  logic [DIST_W-1:0]       nd_fg_r, nd_fg_nxt;
  logic [DIST_W-1:0]       nd_bg_r, nd_bg_nxt;
  logic [DIST_W-1:0]       mn_fg_r, mn_fg_nxt;
  logic [DIST_W-1:0]       mn_bg_r, mn_bg_nxt;

  logic [PICK_W-1:0]  o_fg_pick_r, o_fg_pick_nxt;
  logic [PICK_W-1:0]  o_bg_pick_r, o_bg_pick_nxt;
  logic [SCORE_W-1:0] o_score_r, o_score_nxt;
  logic [ALPHA_W-1:0] o_alpha_r, o_alpha_nxt;

  // distance memory: bg in the high half, fg in the low half
  logic [2*DIST_W-1:0] dist_mem [MAX_PIXELS];
  logic [2*DIST_W-1:0] rd_q;
  logic                mem_we;
  logic [SLOT_W-1:0]   mem_wa;
  logic [2*DIST_W-1:0] mem_wd;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      dist_mem[mem_wa] <= mem_wd;
    end
    rd_q <= dist_mem[slot_r];
  end

  // channel and coordinate operands
  logic [1:0]               ch;
  logic [RGB_W-1:0]         f_rgb, b_rgb;
  logic [CHAN_W-1:0]        fc, bc, pc;
  logic signed [CHAN_W:0]   fb_d, pb_d;
  logic [XY_W-1:0]          s_xy;
  logic signed [COORD_W:0]  dx, dy;

  always_comb begin
    ch = 2'd0;
    if (state_r == S_ND) begin
      ch = (cnt_r < 5'd3) ? cnt_r[1:0] : 2'(cnt_r - 5'd3);
    end else if (state_r == S_RES) begin
      ch = cnt_r[2:1];
    end
  end

  assign f_rgb = emit_r ? best_fg_rgb_r : fg_rgb_r;
  assign b_rgb = emit_r ? best_bg_rgb_r : bg_rgb_r;
  assign fc    = f_rgb[ch*CHAN_W +: CHAN_W];
  assign bc    = b_rgb[ch*CHAN_W +: CHAN_W];
  assign pc    = pix_rgb_r[ch*CHAN_W +: CHAN_W];
  assign fb_d  = $signed({1'b0, fc}) - $signed({1'b0, bc});
  assign pb_d  = $signed({1'b0, pc}) - $signed({1'b0, bc});
  assign s_xy  = side_r ? bg_xy_r : fg_xy_r;
  assign dx    = $signed({1'b0, s_xy[COORD_W-1:0]}) - $signed({1'b0, pix_xy_r[COORD_W-1:0]});
  assign dy    = $signed({1'b0, s_xy[XY_W-1:COORD_W]})
               - $signed({1'b0, pix_xy_r[XY_W-1:COORD_W]});

  // shared multiplier
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_ND: begin
        mul_a = (cnt_r < 5'd3) ? {{(MUL_W-CHAN_W-1){pb_d[CHAN_W]}}, pb_d}
                               : {{(MUL_W-CHAN_W-1){fb_d[CHAN_W]}}, fb_d};
        mul_b = {{(MUL_W-CHAN_W-1){fb_d[CHAN_W]}}, fb_d};
      end
      S_RES: begin
        if (!cnt_r[0]) begin
          mul_a = $signed({{(MUL_W-ALPHA_W){1'b0}}, alpha_r});
          mul_b = {{(MUL_W-CHAN_W-1){fb_d[CHAN_W]}}, fb_d};
        end else begin
          mul_a = rr_r;
          mul_b = rr_r;
        end
      end
      S_CSCALE: begin
        mul_a = $signed({1'b0, sres_r[DIV_W-1:0]});
        mul_b = 27'sd255;
      end
      S_DSQ: begin
        mul_a = cnt_r[0] ? {{(MUL_W-COORD_W-1){dy[COORD_W]}}, dy}
                         : {{(MUL_W-COORD_W-1){dx[COORD_W]}}, dx};
        mul_b = mul_a;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  // shared restoring divider step
  logic [REM_W-1:0]   rem_sh, rem_step, d_ext;
  logic               div_ge;
  logic [RATIO_W-1:0] quo_step;

  assign rem_sh   = {rem_r[REM_W-2:0], dlow_r[RATIO_W-1]};
  assign d_ext    = {1'b0, div_d_r};
  assign div_ge   = rem_sh >= d_ext;
  assign rem_step = div_ge ? rem_sh - d_ext : rem_sh;
  assign quo_step = {quo_r[RATIO_W-2:0], div_ge};

  // shared square-root step
  logic [SQ_W:0]   sq_t, sres_step;
  logic            sq_ge;
  logic [SQ_W-1:0] sv_step;

  assign sq_t      = sres_r + {1'b0, sbit_r};
  assign sq_ge     = {1'b0, sv_r} >= sq_t;
  assign sv_step   = sq_ge ? sv_r - sq_t[SQ_W-1:0] : sv_r;
  assign sres_step = sq_ge ? (sres_r >> 1) + {1'b0, sbit_r} : sres_r >> 1;

  // ratio operands
  logic [DIST_W-1:0]    stored_d, nd_cur, best_d;
  logic [RATIO_W-1:0]   ratio_fix;
  logic [SCORE_W-1:0]   cost_sat;
  logic                 keep;

  assign stored_d = side_r ? rd_q[2*DIST_W-1:DIST_W] : rd_q[DIST_W-1:0];
  assign nd_cur   = side_r ? nd_bg_r : nd_fg_r;
  assign best_d   = (nd_cur < stored_d) ? nd_cur : stored_d;
  assign cost_sat = (cost_r > {1'b0, SCORE_MAX}) ? SCORE_MAX : cost_r[SCORE_W-1:0];
  assign keep     = first_r || (cost_sat < best_score_r);

  always_comb begin
    if (best_d == '0) begin
      ratio_fix = (nd_cur == '0) ? RATIO_ONE : RATIO_MAX;
    end else begin
      ratio_fix = RATIO_MAX;
    end
  end

  always_comb begin
    state_nxt        = state_r;
    cnt_nxt          = cnt_r;
    clr_nxt          = clr_r;
    emit_nxt         = emit_r;
    side_nxt         = side_r;
    sq_dist_nxt      = sq_dist_r;
    out_valid_nxt    = out_valid_r && out_stall;
    best_score_nxt   = best_score_r;
    best_fg_pick_nxt = best_fg_pick_r;
    best_bg_pick_nxt = best_bg_pick_r;
    best_fg_rgb_nxt  = best_fg_rgb_r;
    best_bg_rgb_nxt  = best_bg_rgb_r;
    slot_nxt         = slot_r;
    pix_rgb_nxt      = pix_rgb_r;
    pix_xy_nxt       = pix_xy_r;
    fg_rgb_nxt       = fg_rgb_r;
    fg_xy_nxt        = fg_xy_r;
    bg_rgb_nxt       = bg_rgb_r;
    bg_xy_nxt        = bg_xy_r;
    fg_pick_nxt      = fg_pick_r;
    bg_pick_nxt      = bg_pick_r;
    first_nxt        = first_r;
    last_nxt         = last_r;
    num_nxt          = num_r;
    den_nxt          = den_r;
    alpha_nxt        = alpha_r;
    rem_nxt          = rem_r;
    quo_nxt          = quo_r;
    dlow_nxt         = dlow_r;
    div_d_nxt        = div_d_r;
    rr_nxt           = rr_r;
    sum_nxt          = sum_r;
    sv_nxt           = sv_r;
    sres_nxt         = sres_r;
    sbit_nxt         = sbit_r;
    cost_nxt         = cost_r;
    nd_fg_nxt        = nd_fg_r;
    nd_bg_nxt        = nd_bg_r;
    mn_fg_nxt        = mn_fg_r;
    mn_bg_nxt        = mn_bg_r;
    o_fg_pick_nxt    = o_fg_pick_r;
    o_bg_pick_nxt    = o_bg_pick_r;
    o_score_nxt      = o_score_r;
    o_alpha_nxt      = o_alpha_r;
    mem_we           = 1'b0;
    mem_wa           = clr_r;
    mem_wd           = '1;

    unique case (state_r)
      S_CLEAR: begin
        mem_we  = 1'b1;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == '1) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          slot_nxt    = in_pixel_slot;
          pix_rgb_nxt = in_pixel_rgb;
          pix_xy_nxt  = in_pixel_xy;
          fg_rgb_nxt  = in_fg_rgb;
          fg_xy_nxt   = in_fg_xy;
          bg_rgb_nxt  = in_bg_rgb;
          bg_xy_nxt   = in_bg_xy;
          fg_pick_nxt = in_fg_pick;
          bg_pick_nxt = in_bg_pick;
          first_nxt   = in_first_of_run;
          last_nxt    = in_last_of_run;
          emit_nxt    = 1'b0;
          cnt_nxt     = '0;
          state_nxt   = S_ND;
        end
      end

      S_ND: begin
        if (cnt_r == 5'd0) begin
          num_nxt = prod[MUL_W-1:0];
        end else if (cnt_r < 5'd3) begin
          num_nxt = num_r + prod[MUL_W-1:0];
        end else if (cnt_r == 5'd3) begin
          den_nxt = prod[MUL_W-1:0];
        end else begin
          den_nxt = den_r + prod[MUL_W-1:0];
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == 5'd5) begin
          state_nxt = S_ALPHA;
        end
      end

      S_ALPHA: begin
        cnt_nxt = '0;
        if (den_r == '0 || num_r[MUL_W-1] || num_r == '0) begin
          alpha_nxt = '0;
          state_nxt = emit_r ? S_OUT : S_RES;
        end else if ($unsigned(num_r) >= den_r) begin
          alpha_nxt = ALPHA_ONE;
          state_nxt = emit_r ? S_OUT : S_RES;
        end else begin
          rem_nxt   = $unsigned(num_r);
          div_d_nxt = den_r[DIV_W-1:0];
          dlow_nxt  = '0;
          quo_nxt   = '0;
          state_nxt = S_ADIV;
        end
      end

      S_ADIV: begin
        rem_nxt  = rem_step;
        quo_nxt  = quo_step;
        dlow_nxt = dlow_r << 1;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == 5'd11) begin
          alpha_nxt = {1'b0, quo_step[ALPHA_W-2:0]};
          cnt_nxt   = '0;
          state_nxt = emit_r ? S_OUT : S_RES;
        end
      end

      S_RES: begin
        // even step: residual of one channel, odd step: square it into the sum
        if (!cnt_r[0]) begin
          rr_nxt = {{2{pb_d[CHAN_W]}}, pb_d, {CHAN_W{1'b0}}} - prod[MUL_W-1:0];
        end else if (cnt_r == 5'd1) begin
          sum_nxt = prod[SQ_W-1:0];
        end else begin
          sum_nxt = sum_r + prod[SQ_W-1:0];
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == 5'd5) begin
          sv_nxt      = sum_r + prod[SQ_W-1:0];
          sres_nxt    = '0;
          sbit_nxt    = SQ_BIT0;
          sq_dist_nxt = 1'b0;
          cnt_nxt     = '0;
          state_nxt   = S_SQRT;
        end
      end

      S_SQRT: begin
        sv_nxt   = sv_step;
        sres_nxt = sres_step;
        sbit_nxt = sbit_r >> 2;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == 5'(SQ_STEPS - 1)) begin
          cnt_nxt = '0;
          if (!sq_dist_r) begin
            state_nxt = S_CSCALE;
          end else if (!side_r) begin
            nd_fg_nxt = sres_step[DIST_W-1:0];
            side_nxt  = 1'b1;
            state_nxt = S_DSQ;
          end else begin
            nd_bg_nxt = sres_step[DIST_W-1:0];
            side_nxt  = 1'b0;
            state_nxt = S_RATIO;
          end
        end
      end

      S_CSCALE: begin
        cost_nxt  = {1'b0, prod[33:16]};
        side_nxt  = 1'b0;
        cnt_nxt   = '0;
        state_nxt = S_DSQ;
      end

      S_DSQ: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == 5'd0) begin
          sum_nxt = prod[SQ_W-1:0];
        end else begin
          sv_nxt      = (sum_r + prod[SQ_W-1:0]) << 16;
          sres_nxt    = '0;
          sbit_nxt    = SQ_BIT0;
          sq_dist_nxt = 1'b1;
          cnt_nxt     = '0;
          state_nxt   = S_SQRT;
        end
      end

      S_RATIO: begin
        if (side_r) begin
          mn_bg_nxt = best_d;
        end else begin
          mn_fg_nxt = best_d;
        end
        cnt_nxt = '0;
        // zero best distance, or quotient at least 2^16: fixed ratio
        if (best_d == '0 || {8'b0, nd_cur} >= {best_d, 8'b0}) begin
          cost_nxt = cost_r + COST_W'(ratio_fix);
          if (side_r) begin
            side_nxt  = 1'b0;
            state_nxt = S_UPDATE;
          end else begin
            side_nxt = 1'b1;
          end
        end else begin
          rem_nxt   = {{(REM_W-DIST_W+8){1'b0}}, nd_cur[DIST_W-1:8]};
          div_d_nxt = {1'b0, best_d};
          dlow_nxt  = {nd_cur[7:0], 8'b0};
          quo_nxt   = '0;
          state_nxt = S_RDIV;
        end
      end

      S_RDIV: begin
        rem_nxt  = rem_step;
        quo_nxt  = quo_step;
        dlow_nxt = dlow_r << 1;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == 5'(RATIO_W - 1)) begin
          cost_nxt = cost_r + COST_W'(quo_step);
          cnt_nxt  = '0;
          if (side_r) begin
            side_nxt  = 1'b0;
            state_nxt = S_UPDATE;
          end else begin
            side_nxt  = 1'b1;
            state_nxt = S_RATIO;
          end
        end
      end

      S_UPDATE: begin
        mem_we = 1'b1;
        mem_wa = slot_r;
        mem_wd = {mn_bg_r, mn_fg_r};
        if (keep) begin
          best_score_nxt   = cost_sat;
          best_fg_pick_nxt = fg_pick_r;
          best_bg_pick_nxt = bg_pick_r;
          best_fg_rgb_nxt  = fg_rgb_r;
          best_bg_rgb_nxt  = bg_rgb_r;
        end
        cnt_nxt = '0;
        if (last_r) begin
          emit_nxt  = 1'b1;
          state_nxt = S_ND;
        end else begin
          state_nxt = S_IDLE;
        end
      end

      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          o_fg_pick_nxt = best_fg_pick_r;
          o_bg_pick_nxt = best_bg_pick_r;
          o_score_nxt   = best_score_r;
          o_alpha_nxt   = alpha_r;
          emit_nxt      = 1'b0;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r          <= '0;
      clr_r          <= '0;
      emit_r         <= 1'b0;
      side_r         <= 1'b0;
      sq_dist_r      <= 1'b0;
      out_valid_r    <= 1'b0;
      best_score_r   <= SCORE_MAX;
      best_fg_pick_r <= '0;
      best_bg_pick_r <= '0;
      best_fg_rgb_r  <= '0;
      best_bg_rgb_r  <= '0;
    end else begin
      cnt_r          <= cnt_nxt;
      clr_r          <= clr_nxt;
      emit_r         <= emit_nxt;
      side_r         <= side_nxt;
      sq_dist_r      <= sq_dist_nxt;
      out_valid_r    <= out_valid_nxt;
      best_score_r   <= best_score_nxt;
      best_fg_pick_r <= best_fg_pick_nxt;
      best_bg_pick_r <= best_bg_pick_nxt;
      best_fg_rgb_r  <= best_fg_rgb_nxt;
      best_bg_rgb_r  <= best_bg_rgb_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r      <= slot_nxt;
    pix_rgb_r   <= pix_rgb_nxt;
    pix_xy_r    <= pix_xy_nxt;
    fg_rgb_r    <= fg_rgb_nxt;
    fg_xy_r     <= fg_xy_nxt;
    bg_rgb_r    <= bg_rgb_nxt;
    bg_xy_r     <= bg_xy_nxt;
    fg_pick_r   <= fg_pick_nxt;
    bg_pick_r   <= bg_pick_nxt;
    first_r     <= first_nxt;
    last_r      <= last_nxt;
    num_r       <= num_nxt;
    den_r       <= den_nxt;
    alpha_r     <= alpha_nxt;
    rem_r       <= rem_nxt;
    quo_r       <= quo_nxt;
    dlow_r      <= dlow_nxt;
    div_d_r     <= div_d_nxt;
    rr_r        <= rr_nxt;
    sum_r       <= sum_nxt;
    sv_r        <= sv_nxt;
    sres_r      <= sres_nxt;
    sbit_r      <= sbit_nxt;
    cost_r      <= cost_nxt;
    nd_fg_r     <= nd_fg_nxt;
    nd_bg_r     <= nd_bg_nxt;
    mn_fg_r     <= mn_fg_nxt;
    mn_bg_r     <= mn_bg_nxt;
    o_fg_pick_r <= o_fg_pick_nxt;
    o_bg_pick_r <= o_bg_pick_nxt;
    o_score_r   <= o_score_nxt;
    o_alpha_r   <= o_alpha_nxt;
  end

  assign in_stall         = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_best_fg_pick = o_fg_pick_r;
  assign out_best_bg_pick = o_bg_pick_r;
  assign out_best_score   = o_score_r;
  assign out_alpha_value  = o_alpha_r;

  a_alpha_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> o_alpha_r <= ALPHA_ONE)
    else $error("emitted alpha above 1.0");

  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ADIV || state_r == S_RDIV) |-> rem_r < d_ext)
    else $error("divider remainder not below divisor");

  a_dist_min: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_UPDATE |-> (mn_fg_r <= rd_q[DIST_W-1:0]
                             && mn_bg_r <= rd_q[2*DIST_W-1:DIST_W]))
    else $error("distance store would grow");

  a_best_monotone: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPDATE && !first_r) |=> best_score_r <= $past(best_score_r))
    else $error("run best cost rose within a run");

endmodule
